/* rtl/iee_pkg.sv */
// Shared types, operator codes and fixed-point constants of the infix expression evaluator.
`default_nettype none
package iee_pkg;

  localparam int DATA_W        = 64;
  localparam int OPND_W        = 31;
  localparam int FUNC_W        = 3;
  localparam int FRAC_BITS_DEF = 24;

  // Operator codes as they arrive on the input beat.
  localparam logic [FUNC_W-1:0] FUNC_ADD = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_SUB = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_MUL = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_DIV = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_END = 3'd4;

  // Pending operator codes held between beats.
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [DATA_W-1:0] NEG_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] POS_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  typedef struct packed {
    logic start;
    logic is_div;
  } md_ctrl_t;

  typedef struct packed {
    logic done;
    logic err;
  } md_stat_t;

endpackage
`default_nettype wire

/* rtl/iee_muldiv.sv */
// Iterative multiply and divide unit that scales the product term by one operand.
`default_nettype none
module iee_muldiv (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire iee_pkg::md_ctrl_t           ctrl,
  input  wire logic [iee_pkg::DATA_W-1:0]  term,
  input  wire logic [iee_pkg::OPND_W-1:0]  opnd,
  output iee_pkg::md_stat_t                stat,
  output logic      [iee_pkg::DATA_W-1:0]  result
);

  typedef enum logic [2:0] {
    M_IDLE = 3'b001,
    M_RUN  = 3'b010,
    M_FIX  = 3'b100
  } md_state_t;

  md_state_t                      state_r, state_nxt;
  logic [6:0]                     cnt_r, cnt_nxt;
  logic                           div_r, div_nxt;
  logic                           neg_r, neg_nxt;
  logic [iee_pkg::OPND_W-1:0]     k_r, k_nxt;
  logic [iee_pkg::DATA_W-1:0]     mag_r, mag_nxt;
  logic [iee_pkg::DATA_W-1:0]     hi_r, hi_nxt;
  logic [iee_pkg::OPND_W-1:0]     lo_r, lo_nxt;
  logic [iee_pkg::OPND_W:0]       rem_r, rem_nxt;

  logic [iee_pkg::DATA_W:0]       msum;
  logic [iee_pkg::OPND_W:0]       trial;
  logic [iee_pkg::OPND_W+1:0]     diff;
  logic                           ge;
  logic [iee_pkg::DATA_W-1:0]     in_mag;
  logic [iee_pkg::DATA_W-1:0]     p64;
  logic [iee_pkg::DATA_W-1:0]     limit;
  logic [iee_pkg::DATA_W-1:0]     mag_out;
  logic                           over;
  logic                           kzero;

  assign in_mag = term[iee_pkg::DATA_W-1] ? (~term + 64'd1) : term;

  // One shift-add step of the multiply, least significant multiplier bit first.
  assign msum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, mag_r} : {(iee_pkg::DATA_W+1){1'b0}});

  // One restoring step of the divide; the remainder stays below the divisor.
  assign trial = {rem_r[iee_pkg::OPND_W-1:0], hi_r[iee_pkg::DATA_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, k_r};
  assign ge    = ~diff[iee_pkg::OPND_W+1];

  // The full product has 95 bits: upper part in hi_r, lower 31 bits in lo_r.
  assign p64     = {hi_r[32:0], lo_r};
  assign limit   = neg_r ? iee_pkg::NEG_MIN : iee_pkg::POS_MAX;
  assign over    = (|hi_r[iee_pkg::DATA_W-1:33]) || (p64 > limit);
  assign kzero   = (k_r == '0);
  assign mag_out = div_r ? hi_r : p64;

  always_comb begin
    if (div_r && kzero) begin
      result = term;
    end else if (!div_r && over) begin
      result = neg_r ? iee_pkg::NEG_MIN : iee_pkg::POS_MAX;
    end else begin
      result = neg_r ? (~mag_out + 64'd1) : mag_out;
    end
    stat.done = (state_r == M_FIX);
    stat.err  = div_r ? kzero : over;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    div_nxt   = div_r;
    neg_nxt   = neg_r;
    k_nxt     = k_r;
    mag_nxt   = mag_r;
    hi_nxt    = hi_r;
    lo_nxt    = lo_r;
    rem_nxt   = rem_r;
    unique case (state_r)
      M_IDLE: begin
        if (ctrl.start) begin
          div_nxt   = ctrl.is_div;
          neg_nxt   = term[iee_pkg::DATA_W-1];
          k_nxt     = opnd;
          mag_nxt   = in_mag;
          hi_nxt    = ctrl.is_div ? in_mag : '0;
          lo_nxt    = opnd;
          rem_nxt   = '0;
          cnt_nxt   = ctrl.is_div ? 7'(iee_pkg::DATA_W - 1) : 7'(iee_pkg::OPND_W - 1);
          state_nxt = M_RUN;
        end
      end
      M_RUN: begin
        if (div_r) begin
          rem_nxt = ge ? diff[iee_pkg::OPND_W:0] : trial;
          hi_nxt  = {hi_r[iee_pkg::DATA_W-2:0], ge};
        end else begin
          hi_nxt = msum[iee_pkg::DATA_W:1];
          lo_nxt = {msum[0], lo_r[iee_pkg::OPND_W-1:1]};
        end
        cnt_nxt = cnt_r - 7'd1;
        if (cnt_r == 7'd0) begin
          state_nxt = M_FIX;
        end
      end
      M_FIX: begin
        state_nxt = M_IDLE;
      end
      default: begin
        state_nxt = M_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_r <= div_nxt;
    neg_r <= neg_nxt;
    k_r   <= k_nxt;
    mag_r <= mag_nxt;
    hi_r  <= hi_nxt;
    lo_r  <= lo_nxt;
    rem_r <= rem_nxt;
  end

endmodule
`default_nettype wire

/* rtl/infix_expression_evaluator.sv */
// Top level of the infix expression evaluator with sequencer, running sum and result register.
//
// Each input beat carries one non-negative integer operand (in_tdata) and the
// operator that follows it (in_tuser: add, subtract, multiply, divide or end).
// Multiply and divide chains build a product term, add and subtract close the
// term into a signed running sum, and an end beat sends the sum as one output
// beat (out_tdata, signed fixed point with FRAC_BITS fraction bits) together
// with an error flag (out_tuser) for saturation or division by zero. The
// expression state then returns to its reset values for the next expression.
// The block takes one beat at a time. A beat after add or subtract goes to the
// close step and then back to ready; after multiply or divide it first waits
// for the shared unit, which retires one multiplier or quotient bit per cycle,
// before the close step. An end beat reaches out_tvalid in the cycle after
// its close step. The result sits in an output register, so the block keeps
// taking beats while the receiver stalls, until a second end beat has to wait
// for that register. Synchronous reset clears the sum, the error flag, the
// pending operator (add) and the output valid, and sets the term to 1.0.
`default_nettype none
module infix_expression_evaluator #(
  parameter int FRAC_BITS = iee_pkg::FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [30:0] operand, [31] zero
  input  wire logic [2:0]  in_tuser,   // [2:0] func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // [63:0] value
  output logic [0:0]       out_tuser   // [0] error
);

  localparam logic [iee_pkg::DATA_W-1:0] ONE_FIX = 64'd1 << FRAC_BITS;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_WAIT  = 3'b010,
    S_CLOSE = 3'b100
  } state_t;

  state_t                          state_r, state_nxt;
  logic [iee_pkg::DATA_W-1:0]      sum_r, sum_nxt;
  logic [iee_pkg::DATA_W-1:0]      term_r, term_nxt;
  logic [1:0]                      pend_r, pend_nxt;
  logic                            err_r, err_nxt;
  logic [iee_pkg::FUNC_W-1:0]      func_r, func_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [iee_pkg::DATA_W-1:0]      out_value_r, out_value_nxt;
  logic                            out_err_r, out_err_nxt;

  logic                            in_acc;
  logic                            out_free;
  logic [iee_pkg::DATA_W-1:0]      opq;
  logic [iee_pkg::DATA_W-1:0]      add_raw;
  logic [iee_pkg::DATA_W-1:0]      add_sat;
  logic                            add_ovf;
  logic                            is_chain;
  logic                            is_addsub;
  iee_pkg::md_ctrl_t               md_ctrl;
  iee_pkg::md_stat_t               md_stat;
  logic [iee_pkg::DATA_W-1:0]      md_result;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_err_r;
  assign out_free   = !out_valid_r || out_tready;

  assign opq = iee_pkg::DATA_W'(in_tdata[iee_pkg::OPND_W-1:0]) << FRAC_BITS;

  // Saturating add of the closed term into the running sum.
  assign add_raw = sum_r + term_r;
  assign add_ovf = (sum_r[iee_pkg::DATA_W-1] == term_r[iee_pkg::DATA_W-1]) &&
                   (add_raw[iee_pkg::DATA_W-1] != sum_r[iee_pkg::DATA_W-1]);
  assign add_sat = add_ovf ? (sum_r[iee_pkg::DATA_W-1] ? iee_pkg::NEG_MIN : iee_pkg::POS_MAX)
                           : add_raw;

  assign is_chain  = (func_r == iee_pkg::FUNC_MUL) || (func_r == iee_pkg::FUNC_DIV);
  assign is_addsub = (func_r == iee_pkg::FUNC_ADD) || (func_r == iee_pkg::FUNC_SUB);

  assign md_ctrl.start  = in_acc && ((pend_r == iee_pkg::OP_MUL) || (pend_r == iee_pkg::OP_DIV));
  assign md_ctrl.is_div = (pend_r == iee_pkg::OP_DIV);

  iee_muldiv u_muldiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (md_ctrl),
    .term   (term_r),
    .opnd   (in_tdata[iee_pkg::OPND_W-1:0]),
    .stat   (md_stat),
    .result (md_result)
  );

  always_comb begin
    state_nxt     = state_r;
    sum_nxt       = sum_r;
    term_nxt      = term_r;
    pend_nxt      = pend_r;
    err_nxt       = err_r;
    func_nxt      = func_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_value_nxt = out_value_r;
    out_err_nxt   = out_err_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          func_nxt = in_tuser;
          unique case (pend_r)
            iee_pkg::OP_ADD: begin
              term_nxt  = opq;
              state_nxt = S_CLOSE;
            end
            iee_pkg::OP_SUB: begin
              term_nxt  = ~opq + 64'd1;
              state_nxt = S_CLOSE;
            end
            default: begin
              state_nxt = S_WAIT;
            end
          endcase
        end
      end
      S_WAIT: begin
        if (md_stat.done) begin
          term_nxt  = md_result;
          err_nxt   = err_r || md_stat.err;
          state_nxt = S_CLOSE;
        end
      end
      S_CLOSE: begin
        priority if (is_chain) begin
          pend_nxt  = func_r[1:0];
          state_nxt = S_IDLE;
        end else if (is_addsub) begin
          sum_nxt   = add_sat;
          err_nxt   = err_r || add_ovf;
          term_nxt  = ONE_FIX;
          pend_nxt  = func_r[1:0];
          state_nxt = S_IDLE;
        end else if (out_free) begin
          // End of expression: emit the result and start a fresh one.
          out_valid_nxt = 1'b1;
          out_value_nxt = add_sat;
          out_err_nxt   = err_r || add_ovf;
          sum_nxt       = '0;
          term_nxt      = ONE_FIX;
          pend_nxt      = iee_pkg::OP_ADD;
          err_nxt       = 1'b0;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_CLOSE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sum_r       <= '0;
      term_r      <= ONE_FIX;
      pend_r      <= iee_pkg::OP_ADD;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      term_r      <= term_nxt;
      pend_r      <= pend_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    out_value_r <= out_value_nxt;
    out_err_r   <= out_err_nxt;
  end

  // The shared unit only reports completion while the sequencer waits for it.
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    md_stat.done |-> (state_r == S_WAIT))
    else $error("muldiv completion outside of wait state");

  // A new result only comes out of the close step.
  a_out_from_close: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_CLOSE))
    else $error("result raised outside of close step");

  // After a result the expression state is back at its reset values.
  a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> (sum_r == '0 && term_r == ONE_FIX &&
                           pend_r == iee_pkg::OP_ADD && !err_r))
    else $error("expression state not cleared after result");

  // Closing an additive term restores the term to one.
  a_term_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLOSE && is_addsub) |=> (term_r == ONE_FIX))
    else $error("term not restored after additive close");

endmodule
`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// Testbench for the infix expression evaluator: directed and random expressions checked beat by beat.
module tb_top;

  localparam int FB          = iee_pkg::FRAC_BITS_DEF;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 600;
  localparam int RANDOM_BEATS = 850;

  // Operator codes above end behave as end.
  localparam logic [iee_pkg::FUNC_W-1:0] FUNC_END5 = 3'd5;
  localparam logic [iee_pkg::FUNC_W-1:0] FUNC_END6 = 3'd6;
  localparam logic [iee_pkg::FUNC_W-1:0] FUNC_END7 = 3'd7;
  localparam logic [iee_pkg::OPND_W-1:0] OPND_MAX  = {iee_pkg::OPND_W{1'b1}};

  typedef struct packed {
    logic [iee_pkg::DATA_W-1:0] value;
    logic                       err;
  } expr_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [30:0] operand, [31] zero
  logic [2:0]  in_tuser = '0;   // [2:0] func
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [63:0] out_tdata;       // [63:0] value
  logic [0:0]  out_tuser;       // [0] error

  always #5 clk = ~clk;

  infix_expression_evaluator #(.FRAC_BITS(FB)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Expression state of the in-line evaluator.
  logic [iee_pkg::DATA_W-1:0] sum_acc;
  logic [iee_pkg::DATA_W-1:0] term_acc;
  logic [1:0]                 op_pend;
  logic                       err_acc;
  expr_result_t               value_q[$];
  expr_result_t               want;

  int fail_count   = 0;
  int beat_count   = 0;
  int expr_count   = 0;
  int result_count = 0;
  int flagged_count = 0;

  // Sender pacing and receiver stall controls.
  bit          pace_on   = 1'b0;
  int          burst_left = 0;
  bit          rx_steady = 1'b1;
  int          hold_asks = 0;
  int          hold_done = 0;
  int          hold_left = 0;
  logic [7:0]  stall_pat = 8'hB5;
  int          pat_age   = 0;
  int unsigned cycle_cnt = 0;

  function automatic void clear_expr();
    sum_acc  = '0;
    term_acc = 64'd1 << FB;
    op_pend  = iee_pkg::OP_ADD;
    err_acc  = 1'b0;
  endfunction

  // Applies one accepted beat to the expression state and queues the value on an end.
  function automatic void evaluate_beat(input logic [iee_pkg::OPND_W-1:0] opnd,
                                        input logic [iee_pkg::FUNC_W-1:0] fn);
    logic [iee_pkg::DATA_W-1:0] k;
    logic [iee_pkg::DATA_W-1:0] mag;
    logic [iee_pkg::DATA_W-1:0] lim;
    logic [iee_pkg::DATA_W-1:0] r;
    logic                       neg;
    k   = {{(iee_pkg::DATA_W-iee_pkg::OPND_W){1'b0}}, opnd};
    neg = term_acc[iee_pkg::DATA_W-1];
    mag = neg ? -term_acc : term_acc;
    case (op_pend)
      iee_pkg::OP_ADD: term_acc = k << FB;
      iee_pkg::OP_SUB: term_acc = -(k << FB);
      iee_pkg::OP_MUL: begin
        lim = neg ? iee_pkg::NEG_MIN : iee_pkg::POS_MAX;
        if (k == 0 || mag == 0) begin
          term_acc = '0;
        end else if (mag > lim / k) begin
          err_acc  = 1'b1;
          term_acc = neg ? iee_pkg::NEG_MIN : iee_pkg::POS_MAX;
        end else begin
          r = mag * k;
          term_acc = neg ? -r : r;
        end
      end
      default: begin
        // A zero divisor leaves the term as it was.
        if (k == 0) begin
          err_acc = 1'b1;
        end else begin
          r = mag / k;
          term_acc = neg ? -r : r;
        end
      end
    endcase
    if (fn == iee_pkg::FUNC_MUL || fn == iee_pkg::FUNC_DIV) begin
      op_pend = (fn == iee_pkg::FUNC_MUL) ? iee_pkg::OP_MUL : iee_pkg::OP_DIV;
      return;
    end
    r = sum_acc + term_acc;
    if (sum_acc[iee_pkg::DATA_W-1] == term_acc[iee_pkg::DATA_W-1] &&
        r[iee_pkg::DATA_W-1] != sum_acc[iee_pkg::DATA_W-1]) begin
      err_acc = 1'b1;
      r = sum_acc[iee_pkg::DATA_W-1] ? iee_pkg::NEG_MIN : iee_pkg::POS_MAX;
    end
    sum_acc  = r;
    term_acc = 64'd1 << FB;
    if (fn == iee_pkg::FUNC_ADD || fn == iee_pkg::FUNC_SUB) begin
      op_pend = (fn == iee_pkg::FUNC_ADD) ? iee_pkg::OP_ADD : iee_pkg::OP_SUB;
      return;
    end
    value_q.push_back('{value: sum_acc, err: err_acc});
    expr_count++;
    clear_expr();
  endfunction

  // Offers one beat and returns at the edge that accepts it; valid stays high.
  task automatic send_beat(input logic [iee_pkg::OPND_W-1:0] opnd,
                           input logic [iee_pkg::FUNC_W-1:0] fn);
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, opnd};
    in_tuser  <= fn;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    evaluate_beat(opnd, fn);
    beat_count++;
  endtask

  task automatic pace();
    if (!pace_on) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    in_tvalid <= 1'b0;
    repeat ($urandom_range(1, 12)) @(posedge clk);
    burst_left = $urandom_range(0, 10);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (value_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [iee_pkg::OPND_W-1:0] draw_operand();
    case ($urandom_range(0, 9))
      0:       return '0;
      1, 2, 3: return iee_pkg::OPND_W'($urandom_range(1, 20));
      4, 5:    return iee_pkg::OPND_W'($urandom_range(0, 16'hFFFF));
      6:       return iee_pkg::OPND_W'($urandom_range(0, 24'hFFFFFF));
      7:       return OPND_MAX;
      default: return iee_pkg::OPND_W'($urandom);
    endcase
  endfunction

  task automatic test_precedence();
    // 2 + 3 * 4 - 10 / 4 gives 11.5.
    send_beat(31'd2,  iee_pkg::FUNC_ADD);
    send_beat(31'd3,  iee_pkg::FUNC_MUL);
    send_beat(31'd4,  iee_pkg::FUNC_SUB);
    send_beat(31'd10, iee_pkg::FUNC_DIV);
    send_beat(31'd4,  iee_pkg::FUNC_END);
    drain();
  endtask

  task automatic test_division();
    // A negative quotient truncates toward zero.
    send_beat(31'd0, iee_pkg::FUNC_SUB);
    send_beat(31'd7, iee_pkg::FUNC_DIV);
    send_beat(31'd3, iee_pkg::FUNC_END);
    // Division by zero, closed by a reserved code that acts as end.
    send_beat(31'd5, iee_pkg::FUNC_DIV);
    send_beat(31'd0, FUNC_END5);
    drain();
  endtask

  task automatic test_saturation();
    // Negative product overflow.
    send_beat(31'd0,    iee_pkg::FUNC_SUB);
    send_beat(OPND_MAX, iee_pkg::FUNC_MUL);
    send_beat(OPND_MAX, FUNC_END6);
    // Two terms that fit alone but overflow the sum, both signs.
    send_beat(OPND_MAX, iee_pkg::FUNC_MUL);
    send_beat(31'd255,  iee_pkg::FUNC_ADD);
    send_beat(OPND_MAX, iee_pkg::FUNC_MUL);
    send_beat(31'd255,  FUNC_END7);
    send_beat(31'd0,    iee_pkg::FUNC_SUB);
    send_beat(OPND_MAX, iee_pkg::FUNC_MUL);
    send_beat(31'd255,  iee_pkg::FUNC_SUB);
    send_beat(OPND_MAX, iee_pkg::FUNC_MUL);
    send_beat(31'd255,  iee_pkg::FUNC_END);
    drain();
  endtask

  task automatic test_zero_product();
    send_beat(31'd7, iee_pkg::FUNC_MUL);
    send_beat(31'd0, iee_pkg::FUNC_END);
    drain();
  endtask

  task automatic test_backpressure();
    int i;
    // The receiver holds off while short expressions keep coming, so the
    // output register fills and the block stops taking beats.
    hold_asks++;
    for (i = 0; i < 6; i++) begin
      send_beat(draw_operand(), iee_pkg::FUNC_ADD);
      send_beat(draw_operand(), iee_pkg::FUNC_END);
    end
    drain();
  endtask

  task automatic test_random();
    int sent;
    int len;
    int j;
    logic [iee_pkg::FUNC_W-1:0] mid_ops[4];
    logic [iee_pkg::FUNC_W-1:0] fn;
    mid_ops = '{iee_pkg::FUNC_ADD, iee_pkg::FUNC_SUB, iee_pkg::FUNC_MUL, iee_pkg::FUNC_DIV};
    sent = 0;
    while (sent < RANDOM_BEATS) begin
      // Change the idling style now and then so that quiet stretches occur too.
      if ($urandom_range(0, 29) == 0) pace_on = ~pace_on;
      if ($urandom_range(0, 29) == 0) rx_steady = ~rx_steady;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      for (j = 0; j < len; j++) begin
        if (j == len - 1)
          fn = ($urandom_range(0, 3) == 0) ?
               iee_pkg::FUNC_W'($urandom_range(FUNC_END5, FUNC_END7)) : iee_pkg::FUNC_END;
        else
          fn = mid_ops[$urandom_range(0, 3)];
        pace();
        send_beat(draw_operand(), fn);
        sent++;
      end
      if ($urandom_range(0, 9) == 0) drain();
    end
    drain();
  endtask

  // Receiver: mostly ready or a rotating stall pattern, with a long hold-off on request.
  always @(posedge clk) begin
    if (hold_asks != hold_done) begin
      hold_done  <= hold_asks;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (rx_steady) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= stall_pat[0];
      if (pat_age == 63) begin
        pat_age   <= 0;
        stall_pat <= ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
      end else begin
        pat_age   <= pat_age + 1;
        stall_pat <= {stall_pat[0], stall_pat[7:1]};
      end
    end
  end

  // Every result beat is compared with the oldest expected value.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (value_q.size() == 0) begin
        $error("unexpected result beat: value %h error %b", out_tdata, out_tuser);
        fail_count++;
      end else begin
        want = value_q.pop_front();
        if (out_tdata !== want.value) begin
          $error("value mismatch: expected %h, got %h", want.value, out_tdata);
          fail_count++;
        end
        if (out_tuser[0] !== want.err) begin
          $error("error mismatch: expected %b, got %b", want.err, out_tuser[0]);
          fail_count++;
        end
        result_count++;
        if (want.err) flagged_count++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    clear_expr();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_precedence();
    test_division();
    rx_steady = 1'b0;
    test_saturation();
    test_zero_product();
    test_backpressure();
    test_random();
    repeat (100) @(posedge clk);
    $display("Ran %0d beats forming %0d expressions; %0d results checked, %0d flagged.",
             beat_count, expr_count, result_count, flagged_count);
    $display("Directed precedence, rounding, zero divisor, saturation and hold-off cases ran first.");
    if (fail_count == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule
